// File: src/fpfa_pkg.sv
`default_nettype none

package fpfa_pkg;

  localparam int DEF_NUM_PARTITIONS = 16;
  localparam int DEF_SIZE_BITS      = 16;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 4;
  localparam int KB_W     = 16;
  localparam int PID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ACTIVE_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 1'd1;

  typedef struct packed {
    logic                fit_mode;
    logic [ACTIVE_W-1:0] active;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [KB_W-1:0]     leftover_kb;
    logic [KB_W-1:0]     stored_size_kb;
    logic                is_busy;
    logic [PID_W-1:0]    owner_id;
  } result_t;

endpackage

`default_nettype wire

// File: src/fixed_partition_fit_allocator_top.sv
`default_nettype none

// Fixed-partition allocator with first-fit and worst-fit search over a table of
// partitions held in a single-port-read RAM. A command is taken when start is high
// and busy is low; its result appears on the result ports for exactly one cycle with
// done_o high and must be captured then, as the block cannot be stalled. Loads,
// unused commands, out-of-range accesses and allocations with no usable partition
// deliver their result in the cycle after acceptance and never raise busy. A query
// passes through ST_QUERY, where the registered RAM read data forms its result. An
// allocation scans in ST_SCAN, reading one table entry per cycle through the single
// RAM read port, and then commits the granted entry, if any, in ST_COMMIT. Entries
// are cleared at reset by per-entry valid flags, so there is no clearing pass.
module fixed_partition_fit_allocator_top #(
  parameter int NUM_PARTITIONS = fpfa_pkg::DEF_NUM_PARTITIONS,
  parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fpfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fpfa_pkg::ACTIVE_W-1:0]   cfg_data_i,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fpfa_pkg::CMD_W-1:0]      command_i,
  input  wire logic [fpfa_pkg::INDEX_W-1:0]    part_index_i,
  input  wire logic [fpfa_pkg::KB_W-1:0]       size_kb_i,
  input  wire logic [fpfa_pkg::PID_W-1:0]      process_id_i,
  output logic                                 done_o,
  output logic [fpfa_pkg::STATUS_W-1:0]        status_o,
  output logic [fpfa_pkg::INDEX_W-1:0]         granted_index_o,
  output logic [fpfa_pkg::KB_W-1:0]            leftover_kb_o,
  output logic [fpfa_pkg::KB_W-1:0]            stored_size_kb_o,
  output logic                                 is_busy_o,
  output logic [fpfa_pkg::PID_W-1:0]           owner_id_o
);

  localparam int IDX_W   = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int ENTRY_W = SIZE_BITS + fpfa_pkg::PID_W + 1;

  logic                            fit_mode_q;
  logic [fpfa_pkg::ACTIVE_W-1:0]   active_q;
  fpfa_pkg::cfg_t                  cfg;
  fpfa_pkg::result_t               result;
  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [ENTRY_W-1:0]              ram_wdata;
  logic [IDX_W-1:0]                ram_raddr;
  logic [ENTRY_W-1:0]              ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= 1'b0;
      active_q   <= fpfa_pkg::ACTIVE_W'(12);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fpfa_pkg::REG_FIT_MODE: fit_mode_q <= cfg_data_i[0];
        fpfa_pkg::REG_ACTIVE:   active_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.fit_mode = fit_mode_q;
  assign cfg.active   = active_q;

  fpfa_ctrl #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .SIZE_BITS     (SIZE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start_i      (start),
    .command_i    (command_i),
    .part_index_i (part_index_i),
    .size_kb_i    (size_kb_i),
    .process_id_i (process_id_i),
    .busy_o       (busy),
    .done_o       (done_o),
    .result_o     (result),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  fpfa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_PARTITIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o         = result.status;
  assign granted_index_o  = result.granted_index;
  assign leftover_kb_o    = result.leftover_kb;
  assign stored_size_kb_o = result.stored_size_kb;
  assign is_busy_o        = result.is_busy;
  assign owner_id_o       = result.owner_id;

endmodule

`default_nettype wire

// File: src/fpfa_ram.sv
`default_nettype none

module fpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/fpfa_ctrl.sv
`default_nettype none

module fpfa_ctrl #(
  parameter int NUM_PARTITIONS = fpfa_pkg::DEF_NUM_PARTITIONS,
  parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS,
  localparam int IDX_W   = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1,
  localparam int ENTRY_W = SIZE_BITS + fpfa_pkg::PID_W + 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fpfa_pkg::cfg_t                cfg_i,
  input  wire logic                          start_i,
  input  wire logic [fpfa_pkg::CMD_W-1:0]    command_i,
  input  wire logic [fpfa_pkg::INDEX_W-1:0]  part_index_i,
  input  wire logic [fpfa_pkg::KB_W-1:0]     size_kb_i,
  input  wire logic [fpfa_pkg::PID_W-1:0]    process_id_i,
  output logic                               busy_o,
  output logic                               done_o,
  output fpfa_pkg::result_t                  result_o,
  output logic                               ram_we_o,
  output logic [IDX_W-1:0]                   ram_waddr_o,
  output logic [ENTRY_W-1:0]                 ram_wdata_o,
  output logic [IDX_W-1:0]                   ram_raddr_o,
  input  wire logic [ENTRY_W-1:0]            ram_rdata_i
);

  localparam int CNT_W0 = $clog2(NUM_PARTITIONS + 1);
  localparam int CNT_W  = (CNT_W0 > fpfa_pkg::ACTIVE_W) ? CNT_W0 : fpfa_pkg::ACTIVE_W;
  localparam logic [CNT_W-1:0] NUM_P = CNT_W'(NUM_PARTITIONS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e                         state_q, state_d;
  logic [NUM_PARTITIONS-1:0]      valid_q, valid_d;
  logic                           valid_rd_q;
  logic [fpfa_pkg::INDEX_W-1:0]   idx_q, idx_d;
  logic [SIZE_BITS-1:0]           req_q, req_d;
  logic [fpfa_pkg::PID_W-1:0]     pid_q, pid_d;
  logic [CNT_W-1:0]               n_q, n_d;
  logic [IDX_W-1:0]               chk_q, chk_d;
  logic                           found_q, found_d;
  logic [IDX_W-1:0]               pick_q, pick_d;
  logic [SIZE_BITS-1:0]           best_q, best_d;
  logic [SIZE_BITS-1:0]           pick_size_q, pick_size_d;
  logic                           done_q, done_d;
  fpfa_pkg::result_t              res_q, res_d;

  logic [CNT_W-1:0]               active_ext;
  logic [CNT_W-1:0]               n_now;
  logic                           in_range;
  logic [SIZE_BITS-1:0]           req_now;
  logic [ENTRY_W-1:0]             entry;
  logic [SIZE_BITS-1:0]           e_size;
  logic [fpfa_pkg::PID_W-1:0]     e_owner;
  logic                           e_busy;
  logic                           fits;
  logic [SIZE_BITS-1:0]           left;
  logic                           last;
  logic [SIZE_BITS-1:0]           new_size;

  assign active_ext = CNT_W'(cfg_i.active);
  assign n_now      = (active_ext > NUM_P) ? NUM_P : active_ext;
  assign in_range   = CNT_W'(part_index_i) < n_now;
  assign req_now    = SIZE_BITS'(size_kb_i);

  assign entry   = valid_rd_q ? ram_rdata_i : '0;
  assign e_size  = entry[SIZE_BITS-1:0];
  assign e_owner = entry[SIZE_BITS+fpfa_pkg::PID_W-1:SIZE_BITS];
  assign e_busy  = entry[ENTRY_W-1];
  assign fits    = !e_busy && (e_size >= req_q);
  assign left    = e_size - req_q;
  assign last    = (CNT_W'(chk_q) + CNT_W'(1)) == n_q;
  assign new_size = cfg_i.fit_mode ? best_q : pick_size_q;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    req_d       = req_q;
    pid_d       = pid_q;
    n_d         = n_q;
    chk_d       = chk_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    pick_size_d = pick_size_q;
    done_d      = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pick_q;
    ram_wdata_o = '0;
    ram_raddr_o = chk_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_d   = part_index_i;
          req_d   = req_now;
          pid_d   = process_id_i;
          n_d     = n_now;
          chk_d   = '0;
          found_d = 1'b0;
          best_d  = '0;
          res_d   = '0;
          case (command_i)
            fpfa_pkg::CMD_LOAD: begin
              done_d = 1'b1;
              res_d.granted_index = part_index_i;
              if (in_range) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = IDX_W'(part_index_i);
                ram_wdata_o = {1'b0, {fpfa_pkg::PID_W{1'b0}}, req_now};
                valid_d[IDX_W'(part_index_i)] = 1'b1;
                res_d.status         = fpfa_pkg::STAT_OK;
                res_d.stored_size_kb = fpfa_pkg::KB_W'(req_now);
              end else begin
                res_d.status = fpfa_pkg::STAT_RANGE;
              end
            end
            fpfa_pkg::CMD_QUERY: begin
              if (in_range) begin
                ram_raddr_o = IDX_W'(part_index_i);
                state_d     = ST_QUERY;
              end else begin
                done_d              = 1'b1;
                res_d.status        = fpfa_pkg::STAT_RANGE;
                res_d.granted_index = part_index_i;
              end
            end
            fpfa_pkg::CMD_ALLOC: begin
              if (n_now == '0) begin
                done_d       = 1'b1;
                res_d.status = fpfa_pkg::STAT_NOFIT;
              end else begin
                ram_raddr_o = '0;
                state_d     = ST_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_QUERY: begin
        done_d               = 1'b1;
        res_d.status         = fpfa_pkg::STAT_OK;
        res_d.granted_index  = idx_q;
        res_d.leftover_kb    = '0;
        res_d.stored_size_kb = fpfa_pkg::KB_W'(e_size);
        res_d.is_busy        = e_busy;
        res_d.owner_id       = e_owner;
        state_d              = ST_IDLE;
      end
      ST_SCAN: begin
        ram_raddr_o = chk_q + IDX_W'(1);
        if (fits && (!found_q || (cfg_i.fit_mode && (left > best_q)))) begin
          found_d     = 1'b1;
          pick_d      = chk_q;
          best_d      = left;
          pick_size_d = e_size;
        end
        if (last) begin
          state_d = ST_COMMIT;
        end else begin
          chk_d = chk_q + IDX_W'(1);
        end
      end
      ST_COMMIT: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        res_d   = '0;
        if (found_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pick_q;
          ram_wdata_o = {1'b1, pid_q, new_size};
          valid_d[pick_q] = 1'b1;
          res_d.status         = fpfa_pkg::STAT_OK;
          res_d.granted_index  = fpfa_pkg::INDEX_W'(pick_q);
          res_d.leftover_kb    = fpfa_pkg::KB_W'(best_q);
          res_d.stored_size_kb = fpfa_pkg::KB_W'(new_size);
          res_d.is_busy        = 1'b1;
          res_d.owner_id       = pid_q;
        end else begin
          res_d.status = fpfa_pkg::STAT_NOFIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      valid_rd_q  <= 1'b0;
      idx_q       <= '0;
      req_q       <= '0;
      pid_q       <= '0;
      n_q         <= '0;
      chk_q       <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      best_q      <= '0;
      pick_size_q <= '0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      valid_rd_q  <= valid_q[ram_raddr_o];
      idx_q       <= idx_d;
      req_q       <= req_d;
      pid_q       <= pid_d;
      n_q         <= n_d;
      chk_q       <= chk_d;
      found_q     <= found_d;
      pick_q      <= pick_d;
      best_q      <= best_d;
      pick_size_q <= pick_size_d;
      done_q      <= done_d;
      res_q       <= res_d;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_write_only_idle_or_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_IDLE || state_q == ST_COMMIT))
    else $error("Partition table written outside a load or a commit.");

  a_scan_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(chk_q) < n_q))
    else $error("Scan pointer beyond the usable partitions.");

  a_commit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |=> (state_q == ST_IDLE && done_q))
    else $error("Commit did not deliver a result.");

  a_leftover_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && found_q) |-> (best_q <= pick_size_q))
    else $error("Leftover larger than the chosen partition.");
`endif

endmodule

`default_nettype wire

// File: tb/fixed_partition_fit_allocator_top_tb.sv
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_top_tb;

  localparam int NUM_PARTS = fpfa_pkg::DEF_NUM_PARTITIONS;
  localparam int RANDOM_COMMANDS = 700;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [fpfa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {STEP_COMMAND, STEP_REG_WRITE, STEP_SETTLE} step_kind_e;

  typedef struct packed {
    step_kind_e                     kind;
    logic [fpfa_pkg::CMD_W-1:0]     cmd;
    logic [fpfa_pkg::INDEX_W-1:0]   idx;
    logic [fpfa_pkg::KB_W-1:0]      kb;
    logic [fpfa_pkg::PID_W-1:0]     pid;
    logic [fpfa_pkg::CFG_IDX_W-1:0] reg_sel;
    logic [fpfa_pkg::ACTIVE_W-1:0]  reg_val;
  } step_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [fpfa_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [fpfa_pkg::ACTIVE_W-1:0]  cfg_data_i = '0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [fpfa_pkg::CMD_W-1:0]     command_i = '0;
  logic [fpfa_pkg::INDEX_W-1:0]   part_index_i = '0;
  logic [fpfa_pkg::KB_W-1:0]      size_kb_i = '0;
  logic [fpfa_pkg::PID_W-1:0]     process_id_i = '0;
  logic                           done_o;
  logic [fpfa_pkg::STATUS_W-1:0]  status_o;
  logic [fpfa_pkg::INDEX_W-1:0]   granted_index_o;
  logic [fpfa_pkg::KB_W-1:0]      leftover_kb_o;
  logic [fpfa_pkg::KB_W-1:0]      stored_size_kb_o;
  logic                           is_busy_o;
  logic [fpfa_pkg::PID_W-1:0]     owner_id_o;

  step_t               pending_steps[$];
  fpfa_pkg::result_t   awaited_replies[$];
  int                  issued_count = 0;
  int                  replied_count = 0;
  int                  error_count = 0;
  int                  queued_commands = 0;
  int                  gap_left = 0;
  int                  calm_left = 0;
  longint              cycle_count = 0;

  logic [fpfa_pkg::KB_W-1:0]     part_kb [NUM_PARTS];
  logic                          part_taken [NUM_PARTS];
  logic [fpfa_pkg::PID_W-1:0]    part_owner [NUM_PARTS];
  logic                          worst_fit;
  logic [fpfa_pkg::ACTIVE_W-1:0] active_cnt;

  fixed_partition_fit_allocator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .part_index_i    (part_index_i),
    .size_kb_i       (size_kb_i),
    .process_id_i    (process_id_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .leftover_kb_o   (leftover_kb_o),
    .stored_size_kb_o(stored_size_kb_o),
    .is_busy_o       (is_busy_o),
    .owner_id_o      (owner_id_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                replied_count, name, got, want));
    end
  endtask

  function automatic void set_register(input logic [fpfa_pkg::CFG_IDX_W-1:0] sel,
                                       input logic [fpfa_pkg::ACTIVE_W-1:0] val);
    if (sel == fpfa_pkg::REG_FIT_MODE) begin
      worst_fit = val[0];
    end else begin
      active_cnt = val;
    end
  endfunction

  function automatic fpfa_pkg::result_t apply_command(
      input logic [fpfa_pkg::CMD_W-1:0] cmd,
      input logic [fpfa_pkg::INDEX_W-1:0] idx,
      input logic [fpfa_pkg::KB_W-1:0] req,
      input logic [fpfa_pkg::PID_W-1:0] pid);
    fpfa_pkg::result_t         r;
    int                        usable;
    int                        i;
    int                        pick;
    logic                      found;
    logic [fpfa_pkg::KB_W-1:0] best;
    r = '0;
    usable = (int'(active_cnt) > NUM_PARTS) ? NUM_PARTS : int'(active_cnt);
    found = 1'b0;
    pick = 0;
    best = '0;
    if (cmd == fpfa_pkg::CMD_LOAD || cmd == fpfa_pkg::CMD_QUERY) begin
      r.granted_index = idx;
      if (int'(idx) >= usable) begin
        r.status = fpfa_pkg::STAT_RANGE;
      end else begin
        if (cmd == fpfa_pkg::CMD_LOAD) begin
          part_kb[idx] = req;
          part_taken[idx] = 1'b0;
          part_owner[idx] = '0;
        end
        r.status = fpfa_pkg::STAT_OK;
        r.stored_size_kb = part_kb[idx];
        r.is_busy = part_taken[idx];
        r.owner_id = part_owner[idx];
      end
    end else if (cmd == fpfa_pkg::CMD_ALLOC) begin
      for (i = 0; i < usable; i++) begin
        if (!part_taken[i] && part_kb[i] >= req) begin
          if (!found || (worst_fit && (part_kb[i] - req) > best)) begin
            found = 1'b1;
            pick = i;
            best = part_kb[i] - req;
          end
        end
      end
      if (!found) begin
        r.status = fpfa_pkg::STAT_NOFIT;
      end else begin
        part_taken[pick] = 1'b1;
        part_owner[pick] = pid;
        if (worst_fit) begin
          part_kb[pick] = best;
        end
        r.status = fpfa_pkg::STAT_OK;
        r.granted_index = pick[fpfa_pkg::INDEX_W-1:0];
        r.leftover_kb = best;
        r.stored_size_kb = part_kb[pick];
        r.is_busy = 1'b1;
        r.owner_id = pid;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_command(input logic [fpfa_pkg::CMD_W-1:0] cmd,
                               input logic [fpfa_pkg::INDEX_W-1:0] idx,
                               input logic [fpfa_pkg::KB_W-1:0] kb,
                               input logic [fpfa_pkg::PID_W-1:0] pid);
    step_t s;
    s = '0;
    s.kind = STEP_COMMAND;
    s.cmd = cmd;
    s.idx = idx;
    s.kb = kb;
    s.pid = pid;
    pending_steps.push_back(s);
    queued_commands++;
  endtask

  task automatic queue_reg(input logic [fpfa_pkg::CFG_IDX_W-1:0] sel,
                           input logic [fpfa_pkg::ACTIVE_W-1:0] val);
    step_t s;
    s = '0;
    s.kind = STEP_REG_WRITE;
    s.reg_sel = sel;
    s.reg_val = val;
    pending_steps.push_back(s);
  endtask

  task automatic queue_settle();
    step_t s;
    s = '0;
    s.kind = STEP_SETTLE;
    pending_steps.push_back(s);
  endtask

  function automatic logic [fpfa_pkg::KB_W-1:0] rand_kb(input int lo, input int hi);
    return fpfa_pkg::KB_W'($urandom_range(lo, hi));
  endfunction

  function automatic logic [fpfa_pkg::PID_W-1:0] rand_pid();
    return fpfa_pkg::PID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [fpfa_pkg::INDEX_W-1:0] rand_idx();
    return fpfa_pkg::INDEX_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [fpfa_pkg::KB_W-1:0] rand_request_kb();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 14) return '1;
    if (roll < 50) return rand_kb(1, 2047);
    if (roll < 80) return rand_kb(0, 32767);
    return rand_kb(0, 65535);
  endfunction

  function automatic logic [fpfa_pkg::KB_W-1:0] rand_load_kb();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 15) return '1;
    if (roll < 30) return rand_kb(0, 4095);
    return rand_kb(0, 65535);
  endfunction

  function automatic logic [fpfa_pkg::ACTIVE_W-1:0] rand_active();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 5'd16;
    if (roll < 20) return 5'd1;
    if (roll < 25) return 5'd0;
    if (roll < 35) return fpfa_pkg::ACTIVE_W'($urandom_range(17, 31));
    return fpfa_pkg::ACTIVE_W'($urandom_range(2, 15));
  endfunction

  task automatic build_stimulus();
    int k;
    int ops;
    int roll;
    queue_command(fpfa_pkg::CMD_QUERY, 4'd0, 16'h0000, 8'h00);
    queue_command(fpfa_pkg::CMD_QUERY, 4'd12, 16'hFFFF, 8'hFF);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'h0000, 8'h01);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd0, 16'hFFFF, 8'h00);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd1, 16'd100, 8'h00);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd11, 16'hFFFF, 8'hFF);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd12, 16'd5, 8'h00);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 8'h00);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'hFFFF, 8'hFF);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd15, 16'd101, 8'h80);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'hFFFF, 8'h7F);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'd100, 8'h55);
    queue_command(fpfa_pkg::CMD_QUERY, 4'd11, 16'h0000, 8'h00);
    queue_command(CMD_UNUSED, 4'd15, 16'hFFFF, 8'hFF);
    queue_reg(fpfa_pkg::REG_FIT_MODE, 5'd1);
    queue_reg(fpfa_pkg::REG_ACTIVE, 5'd16);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd13, 16'h8000, 8'h00);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd14, 16'h8000, 8'h00);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd12, 16'h7FFF, 8'h00);
    queue_command(fpfa_pkg::CMD_LOAD, 4'd15, 16'h0001, 8'h00);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'h0001, 8'hAA);
    queue_command(fpfa_pkg::CMD_QUERY, 4'd13, 16'h0000, 8'h00);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'h0000, 8'h00);
    queue_reg(fpfa_pkg::REG_ACTIVE, 5'd0);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'h0000, 8'h11);
    queue_command(fpfa_pkg::CMD_QUERY, 4'd0, 16'h0000, 8'h00);
    queue_reg(fpfa_pkg::REG_ACTIVE, 5'd31);
    queue_command(fpfa_pkg::CMD_QUERY, 4'd15, 16'h0000, 8'h00);
    queue_reg(fpfa_pkg::REG_FIT_MODE, 5'd0);
    queue_reg(fpfa_pkg::REG_ACTIVE, 5'd1);
    queue_command(fpfa_pkg::CMD_ALLOC, 4'd0, 16'h0000, 8'h22);

    ops = queued_commands + RANDOM_COMMANDS;
    while (queued_commands < ops) begin
      if ($urandom_range(0, 1) == 0) begin
        queue_reg(fpfa_pkg::REG_FIT_MODE,
                  ($urandom_range(0, 99) < 85)
                    ? fpfa_pkg::ACTIVE_W'($urandom_range(0, 1))
                    : fpfa_pkg::ACTIVE_W'($urandom_range(0, 31)));
        queue_reg(fpfa_pkg::REG_ACTIVE, rand_active());
      end else begin
        queue_reg(fpfa_pkg::REG_ACTIVE, rand_active());
        queue_reg(fpfa_pkg::REG_FIT_MODE, fpfa_pkg::ACTIVE_W'($urandom_range(0, 1)));
      end
      for (k = 0; k < NUM_PARTS; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          queue_command(fpfa_pkg::CMD_LOAD, fpfa_pkg::INDEX_W'(k), rand_load_kb(),
                        rand_pid());
        end
      end
      for (k = $urandom_range(15, 40); k > 0; k--) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          queue_command(fpfa_pkg::CMD_ALLOC, rand_idx(), rand_request_kb(), rand_pid());
        end else if (roll < 72) begin
          queue_command(fpfa_pkg::CMD_QUERY, rand_idx(), rand_kb(0, 65535), rand_pid());
        end else if (roll < 87) begin
          queue_command(fpfa_pkg::CMD_LOAD, rand_idx(), rand_load_kb(), rand_pid());
        end else if (roll < 92) begin
          queue_command(CMD_UNUSED, rand_idx(), rand_kb(0, 65535), rand_pid());
        end else begin
          queue_settle();
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_seq
    step_t nxt;
    logic  next_start;
    logic  next_cfg;
    logic  settled;
    int    k;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      command_i <= '0;
      part_index_i <= '0;
      size_kb_i <= '0;
      process_id_i <= '0;
      for (k = 0; k < NUM_PARTS; k++) begin
        part_kb[k] = '0;
        part_taken[k] = 1'b0;
        part_owner[k] = '0;
      end
      worst_fit = 1'b0;
      active_cnt = 5'd12;
    end else begin
      next_start = start;
      next_cfg = cfg_valid_i;
      if (start && !busy) begin
        awaited_replies.push_back(apply_command(command_i, part_index_i, size_kb_i,
                                                process_id_i));
        issued_count++;
        next_start = 1'b0;
        gap_left = pick_gap();
      end
      if (cfg_valid_i && cfg_ready_o) begin
        set_register(cfg_index_i, cfg_data_i);
        next_cfg = 1'b0;
        gap_left = pick_gap();
      end
      settled = (issued_count == replied_count) && !done_o && !busy;
      if (!next_start && !next_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_steps.size() > 0) begin
          nxt = pending_steps[0];
          case (nxt.kind)
            STEP_COMMAND: begin
              void'(pending_steps.pop_front());
              command_i <= nxt.cmd;
              part_index_i <= nxt.idx;
              size_kb_i <= nxt.kb;
              process_id_i <= nxt.pid;
              next_start = 1'b1;
            end
            STEP_REG_WRITE: begin
              if (settled) begin
                void'(pending_steps.pop_front());
                cfg_index_i <= nxt.reg_sel;
                cfg_data_i <= nxt.reg_val;
                next_cfg = 1'b1;
              end
            end
            default: begin
              if (settled) begin
                void'(pending_steps.pop_front());
              end
            end
          endcase
        end
      end
      start <= next_start;
      cfg_valid_i <= next_cfg;
    end
  end

  always @(posedge clk_i) begin : check_seq
    fpfa_pkg::result_t want;
    if (rst_ni && done_o) begin
      replied_count++;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
                                  replied_count));
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", 32'(status_o), 32'(want.status));
        check_field("granted_index", 32'(granted_index_o), 32'(want.granted_index));
        check_field("leftover_kb", 32'(leftover_kb_o), 32'(want.leftover_kb));
        check_field("stored_size_kb", 32'(stored_size_kb_o), 32'(want.stored_size_kb));
        check_field("is_busy", 32'(is_busy_o), 32'(want.is_busy));
        check_field("owner_id", 32'(owner_id_o), 32'(want.owner_id));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_steps.size() != 0 || start || cfg_valid_i ||
           awaited_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (40) @(negedge clk_i);
    if (awaited_replies.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: fixed_partition_fit_allocator_top.f
src/fpfa_pkg.sv
src/fpfa_ram.sv
src/fpfa_ctrl.sv
src/fixed_partition_fit_allocator_top.sv
tb/fixed_partition_fit_allocator_top_tb.sv
